@@ design/sstq_pkg.sv @@
// Shared operation codes and stream layout constants for the sorted software timer queue.
package sstq_pkg;

	// Operation codes carried on s_tuser
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_CREATE  = 2'd1;
	localparam logic [1:0] OP_DESTROY = 2'd2;

	// Field widths of one input item and one result item
	localparam int OP_W      = 2;
	localparam int ID_FIELD_W = 4;
	localparam int TIME_W    = 16;

	// Byte-padded tdata widths
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	// Bit positions inside tdata
	localparam int IN_ID_LO      = 0;
	localparam int IN_TIMEOUT_LO = IN_ID_LO + ID_FIELD_W;
	localparam int IN_RELOAD_LO  = IN_TIMEOUT_LO + TIME_W;
	localparam int IN_USED_W     = IN_RELOAD_LO + TIME_W;
	localparam int OUT_USED_W    = ID_FIELD_W + TIME_W;

endpackage

@@ design/sorted_software_timer_queue.sv @@
// Top level of the sorted software timer queue: slot list, sequencer and expiry stream.
//
// A bank of NUM_TIMERS timer slots kept on one list in insertion order. Items arrive on the
// s_ side (tuser selects tick, create or destroy) and the block takes one item at a time:
// s_tready is low until the item is finished. A tick walks the list once, one entry per
// cycle, counting each slot down and compacting the survivors in place, then hands out
// the results of the expired slots on the m_ side (held while m_tready is low). Expired
// slots with a reload are re-appended at the tail in expiry order as their results leave.
// Create or destroy of an armed slot walks the list the same way to unlink it, and create
// then appends the slot at the tail; create of an idle slot appends it directly, and a
// destroy of an idle slot, a bad slot number or a zero timeout finishes at once. No
// clearing pass is needed after reset.
module sorted_software_timer_queue #(
	parameter int NUM_TIMERS = 16,
	parameter int TICK_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// fields from bit 0: timer_id[3:0], timeout[19:4], reload[35:20], zero pad
	input  logic [sstq_pkg::IN_TDATA_W-1:0]    s_tdata,
	// fields from bit 0: operation[1:0]
	input  logic [sstq_pkg::OP_W-1:0]          s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// fields from bit 0: expired_id[3:0], tick_count[19:4], zero pad
	output logic [sstq_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                               m_tlast
);
	import sstq_pkg::*;

	localparam int ID_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_APPEND,
		ST_EMIT
	} state_t;

	// Control state
	state_t                state_q;
	logic                  tick_mode_q;
	logic                  create_q;
	logic [ID_W-1:0]       tgt_q;
	logic [TICK_WIDTH-1:0] timeout_q;
	logic [ID_W-1:0]       r_q;
	logic [CNT_W-1:0]      w_q;
	logic [CNT_W-1:0]      ne_q;
	logic [ID_W-1:0]       k_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TICK_WIDTH-1:0] tick_q;
	logic [NUM_TIMERS-1:0] armed_q;

	// Slot storage
	logic [ID_W-1:0]       order_q     [NUM_TIMERS];
	logic [ID_W-1:0]       exp_q       [NUM_TIMERS];
	logic [TICK_WIDTH-1:0] remaining_q [NUM_TIMERS];
	logic [TICK_WIDTH-1:0] reload_q    [NUM_TIMERS];

	// Input field decode
	logic [OP_W-1:0]       in_op;
	logic [ID_FIELD_W-1:0] in_id;
	logic [ID_W-1:0]       in_slot;
	logic                  in_ok;
	logic [TICK_WIDTH-1:0] in_timeout;
	logic [TICK_WIDTH-1:0] in_reload;
	logic                  in_acc;

	assign in_op      = s_tuser;
	assign in_id      = s_tdata[IN_ID_LO +: ID_FIELD_W];
	assign in_slot    = ID_W'(in_id);
	assign in_ok      = 32'(in_id) < NUM_TIMERS;
	assign in_timeout = TICK_WIDTH'(s_tdata[IN_TIMEOUT_LO +: TIME_W]);
	assign in_reload  = TICK_WIDTH'(s_tdata[IN_RELOAD_LO +: TIME_W]);
	assign in_acc     = s_tvalid && s_tready;

	// List walk datapath: one entry per cycle
	logic [ID_W-1:0]       walk_slot;
	logic [TICK_WIDTH-1:0] walk_rem;
	logic                  walk_hit;
	logic                  walk_drop;
	logic                  walk_end;
	logic [CNT_W-1:0]      w_next;
	logic [CNT_W-1:0]      ne_next;

	assign walk_slot = order_q[r_q];
	assign walk_rem  = remaining_q[walk_slot];
	assign walk_hit  = walk_rem <= TICK_WIDTH'(1);
	assign walk_drop = tick_mode_q ? walk_hit : (walk_slot == tgt_q);
	assign walk_end  = (CNT_W'(r_q) + CNT_W'(1)) == cnt_q;
	assign w_next    = walk_drop ? w_q : w_q + CNT_W'(1);
	assign ne_next   = (tick_mode_q && walk_drop) ? ne_q + CNT_W'(1) : ne_q;

	// Expiry output
	logic [ID_W-1:0] emit_slot;
	logic            emit_last;
	logic            emit_acc;
	logic            emit_reload;

	assign emit_slot   = exp_q[k_q];
	assign emit_last   = (CNT_W'(k_q) + CNT_W'(1)) == ne_q;
	assign emit_acc    = m_tvalid && m_tready;
	assign emit_reload = reload_q[emit_slot] != '0;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tlast  = emit_last;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, TIME_W'(tick_q),
		ID_FIELD_W'(emit_slot)};

	// Sequencer: hold state, counters and armed flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_mode_q <= 1'b0;
			create_q    <= 1'b0;
			tgt_q       <= '0;
			timeout_q   <= '0;
			r_q         <= '0;
			w_q         <= '0;
			ne_q        <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			tick_q      <= '0;
			armed_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						r_q  <= '0;
						w_q  <= '0;
						ne_q <= '0;
						k_q  <= '0;
						unique case (in_op)
							OP_TICK: begin
								tick_q      <= tick_q + TICK_WIDTH'(1);
								tick_mode_q <= 1'b1;
								if (cnt_q != '0) begin
									state_q <= ST_WALK;
								end
							end
							OP_CREATE: begin
								if (in_ok && in_timeout != '0) begin
									tgt_q       <= in_slot;
									timeout_q   <= in_timeout;
									create_q    <= 1'b1;
									tick_mode_q <= 1'b0;
									state_q     <= armed_q[in_slot] ? ST_WALK : ST_APPEND;
								end
							end
							OP_DESTROY: begin
								if (in_ok && armed_q[in_slot]) begin
									tgt_q       <= in_slot;
									create_q    <= 1'b0;
									tick_mode_q <= 1'b0;
									state_q     <= ST_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					// Unlink the target slot; expired slots stay armed until reported
					if (!tick_mode_q && walk_drop) begin
						armed_q[walk_slot] <= 1'b0;
					end
					r_q  <= r_q + ID_W'(1);
					w_q  <= w_next;
					ne_q <= ne_next;
					if (walk_end) begin
						cnt_q <= w_next;
						if (tick_mode_q) begin
							state_q <= (ne_next != '0) ? ST_EMIT : ST_IDLE;
						end else begin
							state_q <= create_q ? ST_APPEND : ST_IDLE;
						end
					end
				end
				ST_APPEND: begin
					armed_q[tgt_q] <= 1'b1;
					cnt_q          <= cnt_q + CNT_W'(1);
					state_q        <= ST_IDLE;
				end
				ST_EMIT: begin
					// Report one expiry, then re-arm it at the tail or drop it
					if (emit_acc) begin
						if (emit_reload) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							armed_q[emit_slot] <= 1'b0;
						end
						k_q <= k_q + ID_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Slot storage writes
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_ok) begin
					if (in_op == OP_CREATE && in_timeout != '0) begin
						reload_q[in_slot] <= in_reload;
					end else if (in_op == OP_DESTROY) begin
						reload_q[in_slot] <= '0;
					end
				end
			end
			ST_WALK: begin
				// Compact survivors toward the head
				if (!walk_drop) begin
					order_q[w_q[ID_W-1:0]] <= walk_slot;
				end
				if (tick_mode_q) begin
					remaining_q[walk_slot] <= walk_hit ? '0 : walk_rem - TICK_WIDTH'(1);
					if (walk_drop) begin
						exp_q[ne_q[ID_W-1:0]] <= walk_slot;
					end
				end
			end
			ST_APPEND: begin
				order_q[cnt_q[ID_W-1:0]] <= tgt_q;
				remaining_q[tgt_q]       <= timeout_q;
			end
			ST_EMIT: begin
				if (emit_acc && emit_reload) begin
					order_q[cnt_q[ID_W-1:0]] <= emit_slot;
					remaining_q[emit_slot]   <= reload_q[emit_slot];
				end
			end
			default: begin
			end
		endcase
	end

	// List length never exceeds the slot count
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= NUM_TIMERS)
		else $error("list length exceeds slot count");

	// Between items the list length matches the armed flags
	a_cnt_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(armed_q) == 32'(cnt_q)))
		else $error("list length and armed flags disagree");

	// No new item is taken while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while expiries pending");

	// The final expiry of a tick returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("block not idle after final expiry");

	// A walk ends within the list length
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (CNT_W'(r_q) < cnt_q))
		else $error("walk index past list end");

endmodule
